FILE: rtl/matrix_multiply_accumulate_int16_core_defines.svh
// assertion macros for the int16 matrix multiply-accumulate core
// used by the top level only; expects clk and rst in scope
`ifndef MATRIX_MULTIPLY_ACCUMULATE_INT16_CORE_DEFINES_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_INT16_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MMAI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MMAI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mmai_pkg.sv
// shared types and constants for the int16 matrix multiply-accumulate core
// no dependencies
package mmai_pkg;

  // number of column lanes in the cell chain
  localparam int NCELL  = 8;
  // widest index, block and dimension fields carried between modules
  localparam int IDX_W  = 10;
  localparam int BLK_W  = 7;
  localparam int DIM_W  = 11;
  localparam int CFG_W  = 9;

  typedef enum logic [2:0] {
    CMD_WR_A    = 3'd0,
    CMD_WR_B    = 3'd1,
    CMD_WR_C    = 3'd2,
    CMD_COMPUTE = 3'd3,
    CMD_RD_C    = 3'd4
  } cmd_t;

  localparam logic [1:0] REG_NUM_ROWS  = 2'd0;
  localparam logic [1:0] REG_INNER_LEN = 2'd1;
  localparam logic [1:0] REG_NUM_COLS  = 2'd2;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [15:0] value;
  } req_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] data;
  } rsp_t;

  // one step of the multiply-accumulate walk, handed from cell to cell
  typedef struct packed {
    logic             v;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] k;
    logic [BLK_W-1:0] blk;
  } tok_t;

  // element access from the command port, broadcast to all cells
  typedef struct packed {
    logic             wr_b;
    logic             wr_c;
    logic [2:0]       lane;
    logic [IDX_W-1:0] row;
    logic [BLK_W-1:0] blk;
    logic [15:0]      data;
  } host_t;

endpackage

FILE: rtl/matrix_multiply_accumulate_int16_core.sv
// int16 matrix multiply-accumulate, C += A * B, over a chain of 8 column cells
// writes are stored when accepted; a read answers from ST_READ, which stalls input
// compute walks every row and column block of 8 over the inner index; one A element
// per cycle enters the cell chain, then the chain drains before the response
// rst is synchronous and clears control state; stores hold undefined data until written
`include "matrix_multiply_accumulate_int16_core_defines.svh"
module matrix_multiply_accumulate_int16_core #(
  parameter int MAX_DIM = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  mmai_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output mmai_pkg::rsp_t             rsp,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_addr,
  input  logic [mmai_pkg::CFG_W-1:0] cfg_data
);

  localparam int NC     = mmai_pkg::NCELL;
  localparam int DIMW   = $clog2(MAX_DIM + 1);
  localparam int ADEPTH = MAX_DIM * MAX_DIM;
  localparam int AAW    = $clog2(ADEPTH);
  localparam int DRAIN  = NC + 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE,
    ST_READ
  } state_t;

  state_t                    state;
  logic [mmai_pkg::CFG_W-1:0] num_rows;
  logic [mmai_pkg::CFG_W-1:0] inner_len;
  logic [mmai_pkg::CFG_W-1:0] num_cols;
  logic [DIMW-1:0]           rows_c;
  logic [DIMW-1:0]           inner_c;
  logic [DIMW-1:0]           cols_c;
  logic [DIMW-1:0]           nblk;
  logic [DIMW-1:0]           i_cnt;
  logic [DIMW-1:0]           k_cnt;
  logic [DIMW-1:0]           blk_cnt;
  logic [3:0]                drain_cnt;
  logic                      accept;
  logic                      ok;
  logic                      rd_ok;
  logic [2:0]                lane_q;
  logic [15:0]               a_mem [ADEPTH];
  logic [AAW-1:0]            a_waddr;
  logic [AAW-1:0]            a_raddr;
  logic [15:0]               a_q;
  mmai_pkg::tok_t            tok_c [NC+1];
  logic [15:0]               a_c   [NC+1];
  logic [15:0]               rd_data [NC];
  mmai_pkg::host_t           host;
  logic                      last_k;
  logic                      last_blk;
  logic                      last_i;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows  <= mmai_pkg::CFG_W'(256);
      inner_len <= mmai_pkg::CFG_W'(256);
      num_cols  <= mmai_pkg::CFG_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mmai_pkg::REG_NUM_ROWS:  num_rows  <= cfg_data;
        mmai_pkg::REG_INNER_LEN: inner_len <= cfg_data;
        mmai_pkg::REG_NUM_COLS:  num_cols  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sizes in use, clamped to the store
  assign rows_c  = (32'(num_rows)  > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(num_rows);
  assign inner_c = (32'(inner_len) > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(inner_len);
  assign cols_c  = (32'(num_cols)  > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(num_cols);
  assign nblk    = DIMW'((32'(cols_c) + NC - 1) >> 3);

  // command port
  assign req_stall = (state != ST_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign ok        = (32'(req.row) < MAX_DIM) && (32'(req.col) < MAX_DIM);

  always_comb begin
    host.wr_b = accept && (req.cmd == mmai_pkg::CMD_WR_B) && ok;
    host.wr_c = accept && (req.cmd == mmai_pkg::CMD_WR_C) && ok;
    host.lane = req.col[2:0];
    host.row  = mmai_pkg::IDX_W'(req.row);
    host.blk  = mmai_pkg::BLK_W'(req.col[7:3]);
    host.data = req.value;
  end

  // A store and its walk read port
  assign a_waddr = AAW'(32'(req.row) * MAX_DIM + 32'(req.col));
  assign a_raddr = AAW'(32'(i_cnt) * MAX_DIM + 32'(k_cnt));

  always_ff @(posedge clk) begin
    if (accept && (req.cmd == mmai_pkg::CMD_WR_A) && ok) begin
      a_mem[a_waddr] <= req.value;
    end
    a_q <= a_mem[a_raddr];
  end

  // walk position
  assign last_k   = (k_cnt == inner_c - DIMW'(1));
  assign last_blk = (blk_cnt == nblk - DIMW'(1));
  assign last_i   = (i_cnt == rows_c - DIMW'(1));

  // sequencer, step issue and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      tok_c[0].v <= 1'b0;
    end else begin
      tok_c[0].v <= (state == ST_RUN);
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          i_cnt   <= '0;
          k_cnt   <= '0;
          blk_cnt <= '0;
          drain_cnt <= 4'(DRAIN);
          if (accept && (req.cmd == mmai_pkg::CMD_COMPUTE)) begin
            if ((rows_c == '0) || (inner_c == '0) || (cols_c == '0)) begin
              state <= ST_DONE;
            end else begin
              state <= ST_RUN;
            end
          end else if (accept && (req.cmd == mmai_pkg::CMD_RD_C)) begin
            state <= ST_READ;
          end
        end
        ST_RUN: begin
          if (last_k) begin
            k_cnt <= '0;
            if (last_blk) begin
              blk_cnt <= '0;
              if (last_i) begin
                state <= ST_DRAIN;
              end else begin
                i_cnt <= i_cnt + DIMW'(1);
              end
            end else begin
              blk_cnt <= blk_cnt + DIMW'(1);
            end
          end else begin
            k_cnt <= k_cnt + DIMW'(1);
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt - 4'd1;
          if (drain_cnt == 4'd0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp.kind  <= mmai_pkg::KIND_DONE;
            rsp.data  <= '0;
            state     <= ST_IDLE;
          end
        end
        ST_READ: begin
          rsp_valid <= 1'b1;
          rsp.kind  <= mmai_pkg::KIND_READ;
          rsp.data  <= rd_ok ? rd_data[lane_q] : '0;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
    // step fields travel with the A element read this cycle
    tok_c[0].first <= (k_cnt == '0);
    tok_c[0].last  <= last_k;
    tok_c[0].i     <= mmai_pkg::IDX_W'(i_cnt);
    tok_c[0].k     <= mmai_pkg::IDX_W'(k_cnt);
    tok_c[0].blk   <= mmai_pkg::BLK_W'(blk_cnt);
    rd_ok          <= ok;
    lane_q         <= req.col[2:0];
  end

  assign a_c[0] = a_q;

  // chain of column cells
  for (genvar g = 0; g < NC; g++) begin : g_cell
    mmai_cell #(
      .MAX_DIM (MAX_DIM),
      .LANE    (g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok_c[g]),
      .a_in    (a_c[g]),
      .host    (host),
      .cols    (mmai_pkg::DIM_W'(cols_c)),
      .tok_out (tok_c[g+1]),
      .a_out   (a_c[g+1]),
      .rd_data (rd_data[g])
    );
  end

  // checks
  `MMAI_ASSERT_NOW(a_busy_stalls, (state != ST_IDLE), req_stall, "input taken while busy")
  `MMAI_ASSERT_NOW(a_idle_no_steps, (state == ST_IDLE), !tok_c[0].v, "step issued while idle")
  `MMAI_ASSERT_NEXT(a_read_answers, (state == ST_READ), rsp_valid && rsp.kind, "read lost")
  `MMAI_ASSERT_NOW(a_done_zero, rsp_valid && !rsp.kind, rsp.data == '0, "done with data")

endmodule

FILE: rtl/mmai_cell.sv
// one lane of the multiply-accumulate chain: owns the B and C columns of its lane
// depends on mmai_pkg
module mmai_cell #(
  parameter int MAX_DIM = 256,
  parameter int LANE    = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mmai_pkg::tok_t           tok_in,
  input  logic [15:0]              a_in,
  input  mmai_pkg::host_t          host,
  input  logic [mmai_pkg::DIM_W-1:0] cols,
  output mmai_pkg::tok_t           tok_out,
  output logic [15:0]              a_out,
  output logic [15:0]              rd_data
);

  localparam int NB    = (MAX_DIM + mmai_pkg::NCELL - 1) / mmai_pkg::NCELL;
  localparam int DEPTH = MAX_DIM * NB;
  localparam int BKW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [15:0]    b_mem [DEPTH];
  logic [15:0]    c_mem [DEPTH];
  logic [BKW-1:0] b_addr;
  logic [BKW-1:0] c_addr;
  logic [BKW-1:0] h_addr;
  logic [BKW-1:0] s1_addr;
  logic           sel;
  logic [15:0]    b_q;
  logic [15:0]    acc;
  logic [31:0]    prod;
  logic [15:0]    acc_next;
  logic           col_ok;
  logic           c_wr;

  // stage 0 addresses
  assign b_addr = BKW'(32'(tok_in.k) * NB + 32'(tok_in.blk));
  assign c_addr = BKW'(32'(tok_in.i) * NB + 32'(tok_in.blk));
  assign h_addr = BKW'(32'(host.row) * NB + 32'(host.blk));
  assign sel    = (32'(host.lane) == LANE);

  // stage 1 multiply-accumulate, sums wrap at 16 bits
  assign prod     = a_out * b_q;
  assign acc_next = (tok_out.first ? rd_data : acc) + prod[15:0];
  assign col_ok   = (32'(tok_out.blk) * mmai_pkg::NCELL + LANE) < 32'(cols);
  assign c_wr     = tok_out.v && tok_out.last && col_ok;

  // b column bank
  always_ff @(posedge clk) begin
    if (host.wr_b && sel) begin
      b_mem[h_addr] <= host.data;
    end
    b_q <= b_mem[b_addr];
  end

  // c column bank, shared by the walk and the command port
  always_ff @(posedge clk) begin
    if (host.wr_c && sel) begin
      c_mem[h_addr] <= host.data;
    end else if (c_wr) begin
      c_mem[s1_addr] <= acc_next;
    end
    rd_data <= c_mem[tok_in.v ? c_addr : h_addr];
  end

  // hand the step to the neighbor and keep the running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.v <= 1'b0;
    end else begin
      tok_out.v <= tok_in.v;
    end
    tok_out.first <= tok_in.first;
    tok_out.last  <= tok_in.last;
    tok_out.i     <= tok_in.i;
    tok_out.k     <= tok_in.k;
    tok_out.blk   <= tok_in.blk;
    a_out         <= a_in;
    s1_addr       <= c_addr;
    if (tok_out.v) begin
      acc <= acc_next;
    end
  end

endmodule
